// File: rtl/planar_arm_forward_kinematics_defines.svh
// Assertion macros for the planar arm forward kinematics top level.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAFK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAFK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pafk_pkg.sv
// Package: constants, types and the arctangent table of the arm kinematics pipeline.
`timescale 1ns / 1ps
`default_nettype none
package pafk_pkg;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;

    localparam int FULL_TURN   = 46080;
    localparam int TURN_OFFSET = 5 * FULL_TURN;

    // Stages: three for angle reduction, CORDIC (fold, steps, round), multiply, sum.
    localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;
    localparam int PIPE_DEPTH   = 3 + CORDIC_DEPTH + 2;

    localparam logic [1:0] REG_FIRST_LINK  = 2'd0;
    localparam logic [1:0] REG_SECOND_LINK = 2'd1;

    typedef logic signed [15:0] t_trig;
    typedef logic signed [17:0] t_pos;
    typedef logic        [15:0] t_len;

    // Arctangent of 2^-i in degrees times 2^20.
    function automatic logic [25:0] atan_deg20(input int idx);
        logic [25:0] v;
        case (idx)
            0:  v = 26'd47185920;
            1:  v = 26'd27855475;
            2:  v = 26'd14718068;
            3:  v = 26'd7471121;
            4:  v = 26'd3750059;
            5:  v = 26'd1876857;
            6:  v = 26'd938658;
            7:  v = 26'd469357;
            8:  v = 26'd234682;
            9:  v = 26'd117342;
            10: v = 26'd58671;
            11: v = 26'd29335;
            12: v = 26'd14668;
            13: v = 26'd7334;
            14: v = 26'd3667;
            15: v = 26'd1833;
            16: v = 26'd917;
            17: v = 26'd458;
            18: v = 26'd229;
            19: v = 26'd115;
            20: v = 26'd57;
            21: v = 26'd29;
            22: v = 26'd14;
            23: v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: rtl/pafk_cordic.sv
// Pipelined rotation-mode CORDIC: reduced angle in, Q1.14 cosine and sine out.
`timescale 1ns / 1ps
`default_nettype none
module pafk_cordic
    import pafk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_angle,   // [0, 360) degrees times 128
    output t_trig            o_cos,
    output t_trig            o_sin
);
    localparam logic [28:0] DEG90  = 29'd94371840;
    localparam logic [28:0] DEG180 = 29'd188743680;
    localparam logic [28:0] DEG270 = 29'd283115520;
    localparam logic [28:0] DEG360 = 29'd377487360;
    localparam logic signed [31:0] GAIN_Q28 = 32'sd163008219;

    logic signed [31:0] r_x [0:CORDIC_STEPS];
    logic signed [31:0] r_y [0:CORDIC_STEPS];
    logic signed [30:0] r_z [0:CORDIC_STEPS];
    logic               r_neg [0:CORDIC_STEPS];

    logic [28:0]        w_zu;
    logic signed [30:0] n_z0;
    logic               n_neg0;

    // Fold into [-90, 90] degrees; the middle half turn negates the result.
    always_comb begin
        w_zu   = {i_angle, 13'd0};
        n_neg0 = 1'b0;
        if (w_zu >= DEG270) begin
            n_z0 = $signed({2'b00, w_zu}) - $signed({2'b00, DEG360});
        end else if (w_zu > DEG90) begin
            n_z0   = $signed({2'b00, w_zu}) - $signed({2'b00, DEG180});
            n_neg0 = 1'b1;
        end else begin
            n_z0 = $signed({2'b00, w_zu});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= GAIN_Q28;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [30:0] ATAN_K = $signed({5'd0, atan_deg20(k)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                if (!r_z[k][30]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN_K;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN_K;
                end
            end
        end
    end

    function automatic t_trig round_q14(input logic signed [31:0] v, input logic neg);
        logic signed [32:0] s;
        logic signed [18:0] q;
        s = neg ? -$signed({v[31], v}) : $signed({v[31], v});
        s = s + 33'sd8192;
        q = s[32:14];
        if (q > 19'sd16384)       return 16'sd16384;
        else if (q < -19'sd16384) return -16'sd16384;
        else                      return q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= round_q14(r_x[CORDIC_STEPS], r_neg[CORDIC_STEPS]);
            o_sin <= round_q14(r_y[CORDIC_STEPS], r_neg[CORDIC_STEPS]);
        end
    end
endmodule
`default_nettype wire

// File: rtl/planar_arm_forward_kinematics.sv
// Top level: planar three-link arm forward kinematics stream pipeline.
//
// Takes three joint angles (degrees times 128, two's complement) per input beat and
// returns one result beat: cosine and sine (Q1.14) of the three cumulative angles and
// the origins (Q9.8) of frames two and three. Link lengths (unsigned Q8.8, reset 1.0)
// are set through the write port and must only change while the pipeline is empty.
// Angles wrap modulo 360 degrees. The datapath is a fully pipelined chain: three
// reduction stages, three parallel CORDICs of CORDIC_STEPS + 2 stages, a multiply
// stage and a sum stage, and one beat enters every cycle while the output is not stalled.
// The whole pipeline advances together; it holds while the output beat waits on
// m_axis_tready, and a bubble in the output register lets it run.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_arm_forward_kinematics_defines.svh"
module planar_arm_forward_kinematics
    import pafk_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // joint_angle_one[16:0], joint_angle_two[33:17], joint_angle_three[50:34], zero pad
    input  wire logic [55:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // frame_one_cos[15:0], frame_one_sin[31:16], frame_two_cos[47:32],
    // frame_two_sin[63:48], frame_two_x[81:64], frame_two_y[99:82],
    // frame_three_cos[115:100], frame_three_sin[131:116], frame_three_x[149:132],
    // frame_three_y[167:150]
    output logic [167:0]      m_axis_tdata
);
    localparam logic [18:0] OFFSET = 19'(TURN_OFFSET);
    localparam logic [18:0] TURN8  = 19'(8 * FULL_TURN);
    localparam logic [17:0] TURN4  = 18'(4 * FULL_TURN);
    localparam logic [17:0] TURN2  = 18'(2 * FULL_TURN);
    localparam logic [17:0] TURN1  = 18'(FULL_TURN);

    // Configuration
    t_len r_len1, r_len2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= 16'd256;
            r_len2 <= 16'd256;
        end else if (i_cfg_we) begin
            case ({1'b0, i_cfg_addr})
                REG_FIRST_LINK:  r_len1 <= i_cfg_data;
                REG_SECOND_LINK: r_len2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: move every stage when the output register is free or taken.
    logic w_adv;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    logic [PIPE_DEPTH-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    // Stage 1: cumulative sums, offset by five turns to stay positive
    logic signed [16:0] w_a1, w_a2, w_a3;
    logic signed [18:0] w_s1, w_s12, w_s123;
    logic [18:0] r_sum [0:2];
    always_comb begin
        w_a1   = s_axis_tdata[16:0];
        w_a2   = s_axis_tdata[33:17];
        w_a3   = s_axis_tdata[50:34];
        w_s1   = 19'(w_a1);
        w_s12  = w_s1 + 19'(w_a2);
        w_s123 = w_s12 + 19'(w_a3);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum[0] <= w_s1 + $signed(OFFSET);
            r_sum[1] <= w_s12 + $signed(OFFSET);
            r_sum[2] <= w_s123 + $signed(OFFSET);
        end
    end

    // Stage 2 and 3: modulo one turn by conditional subtraction of 8, 4, 2, 1 turns
    logic [17:0] r_mid [0:2];
    logic [15:0] r_red [0:2];
    for (genvar j = 0; j < 3; j++) begin : g_red
        logic [18:0] w_t8;
        logic [17:0] w_t4, w_u2, w_u1;
        always_comb begin
            w_t8 = (r_sum[j] >= TURN8) ? r_sum[j] - TURN8 : r_sum[j];
            w_t4 = (w_t8[17:0] >= TURN4 || w_t8[18]) ? 18'(w_t8 - 19'(TURN4)) : w_t8[17:0];
            w_u2 = (r_mid[j] >= TURN2) ? r_mid[j] - TURN2 : r_mid[j];
            w_u1 = (w_u2 >= TURN1) ? w_u2 - TURN1 : w_u2;
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mid[j] <= w_t4;
                r_red[j] <= w_u1[15:0];
            end
        end
    end

    t_trig w_cos [0:2];
    t_trig w_sin [0:2];
    for (genvar j = 0; j < 3; j++) begin : g_cordic
        pafk_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_angle (r_red[j]),
            .o_cos   (w_cos[j]),
            .o_sin   (w_sin[j])
        );
    end

    // Multiply stage: link length times trig; carry trig values alongside
    logic signed [32:0] r_px2, r_py2, r_px3, r_py3;
    t_trig r_tc [0:2];
    t_trig r_ts [0:2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px2 <= $signed({1'b0, r_len1}) * w_cos[0];
            r_py2 <= $signed({1'b0, r_len1}) * w_sin[0];
            r_px3 <= $signed({1'b0, r_len2}) * w_cos[1];
            r_py3 <= $signed({1'b0, r_len2}) * w_sin[1];
            for (int j = 0; j < 3; j++) begin
                r_tc[j] <= w_cos[j];
                r_ts[j] <= w_sin[j];
            end
        end
    end

    function automatic logic signed [18:0] round_pos(input logic signed [32:0] p);
        logic signed [32:0] s;
        s = p + 33'sd8192;
        return s[32:14];
    endfunction

    function automatic t_pos sat_pos(input logic signed [19:0] v);
        if (v > 20'sd131071)       return 18'sd131071;
        else if (v < -20'sd131072) return -18'sd131072;
        else                       return v[17:0];
    endfunction

    // Output stage: round, add link two terms, saturate
    logic signed [18:0] w_x2, w_y2;
    t_pos n_x2, n_y2, n_x3, n_y3;
    always_comb begin
        w_x2 = round_pos(r_px2);
        w_y2 = round_pos(r_py2);
        n_x2 = sat_pos(20'(w_x2));
        n_y2 = sat_pos(20'(w_y2));
        n_x3 = sat_pos(20'(w_x2) + 20'(round_pos(r_px3)));
        n_y3 = sat_pos(20'(w_y2) + 20'(round_pos(r_py3)));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            m_axis_tdata <= {n_y3, n_x3, r_ts[2], r_tc[2], n_y2, n_x2,
                             r_ts[1], r_tc[1], r_ts[0], r_tc[0]};
        end
    end

    logic w_in_beat;
    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    `PAFK_ASSERT_NEXT(a_in_enters, i_clk, i_rst_n, w_in_beat, r_vld[0], "accepted beat lost at entry")
    `PAFK_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, !w_adv, $stable(r_vld), "valid bits moved during stall")
    `PAFK_ASSERT_SAME(a_reduced, i_clk, i_rst_n, r_vld[2], r_red[0] < 16'(FULL_TURN) && r_red[2] < 16'(FULL_TURN), "angle reduction out of range")
    `PAFK_ASSERT_SAME(a_trig_range, i_clk, i_rst_n, m_axis_tvalid, $signed(m_axis_tdata[15:0]) <= 16'sd16384 && $signed(m_axis_tdata[15:0]) >= -16'sd16384, "cosine out of range")
endmodule
`default_nettype wire

// File: dv/planar_arm_forward_kinematics_checker.sv
// Result checker for the planar arm kinematics pipeline: predicts each pose and compares it.
`timescale 1ns / 1ps
module planar_arm_forward_kinematics_checker
    import pafk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [55:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [167:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    localparam longint QUARTER  = 64'sd94371840;
    localparam longint HALF     = 64'sd188743680;
    localparam longint THREE_Q  = 64'sd283115520;
    localparam longint WHOLE    = 64'sd377487360;
    localparam longint GAIN_Q28 = 64'sd163008219;

    t_len         link_one_len;
    t_len         link_two_len;
    logic [167:0] pose_queue[$];

    function automatic longint round14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotation-mode CORDIC on the folded angle; returns {cos, sin}.
    function automatic logic [31:0] trig_of(longint angle_sum);
        longint r, z, x, y, dx, dy, c, s;
        bit flip;
        r = angle_sum % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        z = r * 8192;
        flip = 0;
        if (z >= THREE_Q) begin
            z -= WHOLE;
        end else if (z > QUARTER) begin
            z -= HALF;
            flip = 1;
        end
        x = GAIN_Q28;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_deg20(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_deg20(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip(round14(x), -16384, 16384);
        s = clip(round14(y), -16384, 16384);
        return {c[15:0], s[15:0]};
    endfunction

    function automatic logic [167:0] predict_pose(logic [55:0] angles);
        longint a1, a2, a3, c1, s1, c12, s12, c123, s123, x2, y2, x3, y3;
        logic [31:0] cs;
        a1 = longint'($signed(angles[16:0]));
        a2 = longint'($signed(angles[33:17]));
        a3 = longint'($signed(angles[50:34]));
        cs = trig_of(a1);           c1 = $signed(cs[31:16]);   s1 = $signed(cs[15:0]);
        cs = trig_of(a1 + a2);      c12 = $signed(cs[31:16]);  s12 = $signed(cs[15:0]);
        cs = trig_of(a1 + a2 + a3); c123 = $signed(cs[31:16]); s123 = $signed(cs[15:0]);
        x2 = round14(longint'(link_one_len) * c1);
        y2 = round14(longint'(link_one_len) * s1);
        x3 = clip(x2 + round14(longint'(link_two_len) * c12), -131072, 131071);
        y3 = clip(y2 + round14(longint'(link_two_len) * s12), -131072, 131071);
        x2 = clip(x2, -131072, 131071);
        y2 = clip(y2, -131072, 131071);
        return {y3[17:0], x3[17:0], s123[15:0], c123[15:0], y2[17:0], x2[17:0],
                s12[15:0], c12[15:0], s1[15:0], c1[15:0]};
    endfunction

    assign o_pending = pose_queue.size();

    always @(posedge i_clk) begin
        logic [167:0] want;
        if (!i_rst_n) begin
            link_one_len <= 16'd256;
            link_two_len <= 16'd256;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_FIRST_LINK[0:0]) link_one_len <= i_cfg_data;
                else link_two_len <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) pose_queue.push_back(predict_pose(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pose_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pose_queue.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("pose mismatch: expected %h actual %h", want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: dv/planar_arm_forward_kinematics_tb.sv
// Testbench top: drives joint angles and link lengths, stalls both sides, gives the verdict.
`timescale 1ns / 1ps
module planar_arm_forward_kinematics_tb;
    import pafk_pkg::*;

    localparam int ANGLE_LIMIT = 46080;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_addr = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off_cycles = 0;

    always #6 i_clk = ~i_clk;

    planar_arm_forward_kinematics dut (.*);

    planar_arm_forward_kinematics_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: end the run on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("planar_arm_forward_kinematics test failed");
            $finish;
        end
    end

    // Receiver: a long hold-off takes priority, otherwise stall at the phase's rate.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [16:0] pick_angle();
        case ($urandom_range(9))
            0: return 17'(ANGLE_LIMIT);
            1: return 17'(-ANGLE_LIMIT);
            2: return 17'($urandom_range(8) * 5760);   // multiples of 45 degrees
            3: return 17'(-int'($urandom_range(8) * 5760));
            4: return 17'($urandom_range(2) - 1);
            default: return 17'(int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT);
        endcase
    endfunction

    // Offer one beat, hold it until accepted; random idle cycles after it.
    task automatic send_pose(logic [16:0] a1, logic [16:0] a2, logic [16:0] a3);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, a3, a2, a1};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Wait until every expected pose has arrived, then write a link length.
    task automatic write_link(logic [0:0] idx, logic [15:0] len);
        while (pending != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] len_set[5][2];
        len_set = '{'{16'hFFFF, 16'hFFFF}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'h0000},
                    '{16'h0100, 16'h8000}, '{16'h1234, 16'h0FED}};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: angle extremes, quadrant edges, the wrap past 360 degrees.
        send_pose(17'd0, 17'd0, 17'd0);
        send_pose(17'(ANGLE_LIMIT), 17'(ANGLE_LIMIT), 17'(ANGLE_LIMIT));
        send_pose(17'(-ANGLE_LIMIT), 17'(-ANGLE_LIMIT), 17'(-ANGLE_LIMIT));
        send_pose(17'd11520, 17'd11520, 17'd11520);
        send_pose(17'd23040, 17'd11520, 17'd1);
        send_pose(17'd34560, 17'(-1), 17'd11519);
        send_pose(17'd11521, 17'd23039, 17'd34561);
        send_pose(17'(ANGLE_LIMIT), 17'(ANGLE_LIMIT), 17'(-ANGLE_LIMIT));
        send_pose(17'h1FFFF, 17'h10000, 17'h0FFFF);
        send_pose(17'h0AAAA, 17'h15555, 17'h00001);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            repeat (40) @(posedge i_clk);   // drain pipeline beyond the last result
            write_link(REG_FIRST_LINK[0:0], len_set[ph][0]);
            write_link(REG_SECOND_LINK[0:0], len_set[ph][1]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (ph == 0) hold_off_cycles = 200;   // fill the pipeline and stall its input
            for (int n = 0; n < 120; n++) send_pose(pick_angle(), pick_angle(), pick_angle());
            s_axis_tvalid <= 1'b0;
        end

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("planar_arm_forward_kinematics test passed");
        end else begin
            $display("planar_arm_forward_kinematics test failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/pafk_pkg.sv
rtl/pafk_cordic.sv
rtl/planar_arm_forward_kinematics.sv
dv/planar_arm_forward_kinematics_checker.sv
dv/planar_arm_forward_kinematics_tb.sv
